>>> src/isotd_pkg.sv
// Shared constants and pipeline types for the isometric tile draw setup block.
package isotd_pkg;

  localparam int NUM_TILESETS = 4;
  localparam int ID_W         = 16;
  localparam int CFG_W        = 64;
  localparam int COORD_W      = 21;

  typedef enum logic [2:0] {
    REG_ORIGIN_X     = 3'd0,
    REG_ORIGIN_Y     = 3'd1,
    REG_TILE_WIDTH   = 3'd2,
    REG_TILE_HEIGHT  = 3'd3,
    REG_TS_COUNT     = 3'd4,
    REG_TS_FIRST_IDS = 3'd5,
    REG_TS_COLUMNS   = 3'd6
  } reg_index_t;

  typedef struct packed {
    logic               err;
    logic [1:0]         sel;
    logic signed [19:0] xprod;
    logic [18:0]        yhalf;
  } side_t;

  typedef struct packed {
    logic            valid;
    side_t           side;
    logic [ID_W-1:0] rem;
    logic [ID_W-1:0] dq;
    logic [ID_W-1:0] divisor;
  } cell_t;

endpackage

>>> src/isotd_setup.sv
// Front stage: tileset selection, local index and screen offset products.
module isotd_setup import isotd_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             valid_in,
  input  logic [7:0]       map_row,
  input  logic [7:0]       map_col,
  input  logic [ID_W-1:0]  tile_id,
  input  logic [10:0]      tile_width,
  input  logic [10:0]      tile_height,
  input  logic [2:0]       tileset_count,
  input  logic [CFG_W-1:0] first_ids,
  input  logic [CFG_W-1:0] columns,
  output cell_t            cell_out
);

  logic [2:0]         cnt;
  logic [1:0]         sel;
  logic [ID_W-1:0]    first;
  logic [ID_W-1:0]    cols;
  logic               err;
  logic signed [8:0]  diff_rc;
  logic signed [19:0] xprod;
  logic [19:0]        yprod;

  always_comb begin
    cnt = (tileset_count > 3'(NUM_TILESETS)) ? 3'(NUM_TILESETS) : tileset_count;
    sel = 2'(cnt - 3'd1);
    for (int i = NUM_TILESETS - 2; i >= 0; i--) begin
      if ((3'(i + 1) < cnt) && (tile_id >= first_ids[i*ID_W +: ID_W]) &&
          (tile_id < first_ids[(i+1)*ID_W +: ID_W])) begin
        sel = 2'(i);
      end
    end
    if (cnt == 3'd0) begin
      sel = 2'd0;
    end
    first = first_ids[{sel, 4'b0000} +: ID_W];
    cols  = columns[{sel, 4'b0000} +: ID_W];
    err   = (cnt == 3'd0) || (tile_id < first) || (cols == '0);
    diff_rc = $signed({1'b0, map_col}) - $signed({1'b0, map_row});
    xprod   = 20'(diff_rc * $signed({1'b0, tile_width[10:1]}));
    yprod   = 20'(({1'b0, map_row} + {1'b0, map_col}) * tile_height);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cell_out.valid <= 1'b0;
    end else begin
      cell_out.valid <= valid_in;
    end
    cell_out.side.err   <= err;
    cell_out.side.sel   <= sel;
    cell_out.side.xprod <= xprod;
    cell_out.side.yhalf <= yprod[19:1];
    cell_out.rem        <= '0;
    cell_out.dq         <= tile_id - first;
    cell_out.divisor    <= cols;
  end

endmodule

>>> src/isotd_div_cell.sv
// One restoring division cell: settles one quotient bit and passes the item on.
module isotd_div_cell import isotd_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  cell_t cell_in,
  output cell_t cell_out
);

  logic [ID_W:0] partial;
  logic [ID_W:0] diff;
  logic          ge;

  always_comb begin
    partial = {cell_in.rem, cell_in.dq[ID_W-1]};
    diff    = partial - {1'b0, cell_in.divisor};
    ge      = !diff[ID_W];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cell_out.valid <= 1'b0;
    end else begin
      cell_out.valid <= cell_in.valid;
    end
    cell_out.side    <= cell_in.side;
    cell_out.rem     <= ge ? diff[ID_W-1:0] : partial[ID_W-1:0];
    cell_out.dq      <= {cell_in.dq[ID_W-2:0], ge};
    cell_out.divisor <= cell_in.divisor;
  end

endmodule

>>> src/isometric_tile_draw_setup.sv
// Top level of the isometric tile draw setup block: registers, cell chain, output stage.
// From start to done an item passes one setup stage, sixteen division cells
// (one quotient bit each) and the output register. One transaction is taken every
// cycle; busy stays low, and an empty cell gives no done strobe. A synchronous reset
// empties the pipeline and returns the registers to their reset values.
module isometric_tile_draw_setup import isotd_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  output logic                      busy,
  input  logic [7:0]                map_row,
  input  logic [7:0]                map_col,
  input  logic [ID_W-1:0]           tile_id,
  input  logic                      cfg_write,
  input  logic [2:0]                cfg_index,
  input  logic [CFG_W-1:0]          cfg_data,
  output logic                      done,
  output logic signed [COORD_W-1:0] screen_x,
  output logic signed [COORD_W-1:0] screen_y,
  output logic [1:0]                tileset_index,
  output logic [ID_W-1:0]           source_row,
  output logic [ID_W-1:0]           source_col,
  output logic                      error_flag
);

  logic [15:0]      origin_x;
  logic [15:0]      origin_y;
  logic [10:0]      tile_width;
  logic [10:0]      tile_height;
  logic [2:0]       tileset_count;
  logic [CFG_W-1:0] tileset_first_ids;
  logic [CFG_W-1:0] tileset_columns;
  cell_t            chain [ID_W+1];
  cell_t            last;
  logic [COORD_W-1:0] sx_next;
  logic [COORD_W-1:0] sy_next;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      origin_x          <= '0;
      origin_y          <= '0;
      tile_width        <= 11'd32;
      tile_height       <= 11'd16;
      tileset_count     <= '0;
      tileset_first_ids <= '0;
      tileset_columns   <= '0;
    end else if (cfg_write) begin
      unique case (reg_index_t'(cfg_index))
        REG_ORIGIN_X:     origin_x          <= cfg_data[15:0];
        REG_ORIGIN_Y:     origin_y          <= cfg_data[15:0];
        REG_TILE_WIDTH:   tile_width        <= cfg_data[10:0];
        REG_TILE_HEIGHT:  tile_height       <= cfg_data[10:0];
        REG_TS_COUNT:     tileset_count     <= cfg_data[2:0];
        REG_TS_FIRST_IDS: tileset_first_ids <= cfg_data;
        REG_TS_COLUMNS:   tileset_columns   <= cfg_data;
        default: ;
      endcase
    end
  end

  isotd_setup u_setup (
    .clk           (clk),
    .rst           (rst),
    .valid_in      (start && !busy && (tile_id != '0)),
    .map_row       (map_row),
    .map_col       (map_col),
    .tile_id       (tile_id),
    .tile_width    (tile_width),
    .tile_height   (tile_height),
    .tileset_count (tileset_count),
    .first_ids     (tileset_first_ids),
    .columns       (tileset_columns),
    .cell_out      (chain[0])
  );

  for (genvar k = 0; k < ID_W; k++) begin : g_cell
    isotd_div_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .cell_in  (chain[k]),
      .cell_out (chain[k+1])
    );
  end

  assign last = chain[ID_W];

  always_comb begin
    sx_next = {{5{origin_x[15]}}, origin_x} + {last.side.xprod[19], last.side.xprod}
              + 21'd4;
    sy_next = {{5{origin_y[15]}}, origin_y} + {2'b00, last.side.yhalf} + 21'd4;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= last.valid;
    end
    screen_x      <= sx_next;
    screen_y      <= sy_next;
    tileset_index <= last.side.sel;
    source_row    <= last.side.err ? '0 : last.dq;
    source_col    <= last.side.err ? '0 : last.rem;
    error_flag    <= last.side.err;
  end

endmodule
